// ===== hdl/stpg_pkg.sv =====
// Package for the step/direction pulse generator.
// Holds widths, command and register codes, and the controller types.
// Used by every module of the block but the checker; it depends on nothing.
`default_nettype none

package stpg_pkg;

  localparam int unsigned POS_W       = 8;
  localparam int unsigned STEPS_W     = POS_W + 1;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned DUTY_W      = 7;
  localparam int unsigned TICK_W      = 27;
  localparam int unsigned MINP_W      = 16;
  localparam int unsigned RATE_W      = 20;
  localparam int unsigned PROD_W      = PERIOD_W + DUTY_W;
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned SCALED_W    = PROD_W + RECIP_W;
  localparam int unsigned HQ_W        = SCALED_W - RECIP_SHIFT;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned DIV_CNT_W   = $clog2(TICK_W);

  localparam logic [DUTY_W-1:0]   DUTY_RESET    = DUTY_W'(50);
  localparam logic [TICK_W-1:0]   TICK_HZ_RESET = TICK_W'(1000000);
  localparam logic [MINP_W-1:0]   MINP_RESET    = MINP_W'(3);
  localparam logic [PERIOD_W-1:0] PERIOD_MIN    = PERIOD_W'(2);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX    = {PERIOD_W{1'b1}};
  localparam logic [PERIOD_W-1:0] HIGH_RESET    = PERIOD_W'(1);

  // Reciprocal of 100 scaled by 2^30 and rounded up. The quotient is exact for
  // every product of a period and a duty value.
  localparam logic [RECIP_W-1:0]  RECIP_100     = RECIP_W'(10737419);

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_MOVE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUTY      = 2'd0,
    CFG_TICK_HZ   = 2'd1,
    CFG_MIN_PULSE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_PERIOD,
    ST_MUL,
    ST_SCALE,
    ST_HIGH,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic period_load;
    logic prod_load;
    logic scale_load;
    logic high_load;
    logic move_finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic active;
    logic div_done;
    logic move_req;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== hdl/stpg_if.sv =====
// Channel interfaces of the pulse generator: request, result and register write.
// Widths come from stpg_pkg.
`default_nettype none

interface stpg_req_if;
  logic                               valid;
  logic                               ready;
  logic                               command;
  logic [stpg_pkg::POS_W-1:0]         target_position;
  logic [stpg_pkg::RATE_W-1:0]        step_rate_hz;

  modport source (output valid, command, target_position, step_rate_hz, input ready);
  modport sink   (input valid, command, target_position, step_rate_hz, output ready);
endinterface

interface stpg_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               step_level;
  logic                               direction;
  logic                               enable;
  logic                               busy_res;
  logic [stpg_pkg::POS_W-1:0]         position;
  logic                               move_done;
  logic                               rejected;

  modport source (output valid, step_level, direction, enable, busy_res, position,
                  move_done, rejected, input ready);
  modport sink   (input valid, step_level, direction, enable, busy_res, position,
                  move_done, rejected, output ready);
endinterface

interface stpg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [stpg_pkg::CFG_IDX_W-1:0]     index;
  logic [stpg_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/stpg_div.sv =====
// Restoring divider, one quotient bit per cycle, used for the period
// calculation. Depends on stpg_pkg for its widths.
`default_nettype none

module stpg_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [stpg_pkg::TICK_W-1:0]   dividend_i,
  input  wire logic [stpg_pkg::RATE_W-1:0]   divisor_i,
  output logic                               done_o,
  output logic [stpg_pkg::TICK_W-1:0]        quotient_o
);

  logic [stpg_pkg::TICK_W-1:0]    quo_q;
  logic [stpg_pkg::RATE_W-1:0]    rem_q, rem_d;
  logic [stpg_pkg::RATE_W-1:0]    dvs_q;
  logic [stpg_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q, done_q;
  logic [stpg_pkg::RATE_W:0]      trial;
  logic                           ge;

  always_comb begin
    trial = {rem_q, quo_q[stpg_pkg::TICK_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? stpg_pkg::RATE_W'(trial - {1'b0, dvs_q}) : trial[stpg_pkg::RATE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == stpg_pkg::DIV_CNT_W'(stpg_pkg::TICK_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == stpg_pkg::DIV_CNT_W'(stpg_pkg::TICK_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[stpg_pkg::TICK_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hdl/stpg_datapath.sv =====
// Datapath: configuration registers, move state, pulse timing and result fields.
// Depends on stpg_pkg, stpg_if and stpg_div; sequenced by stpg_ctrl.
`default_nettype none

module stpg_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  stpg_pkg::ctrl_cmd_t       cmd_i,
  output stpg_pkg::ctrl_stat_t      stat_o,
  stpg_req_if.sink                  req_i,
  stpg_cfg_if.sink                  cfg_i,
  output logic                      step_level_o,
  output logic                      direction_o,
  output logic                      active_o,
  output logic [stpg_pkg::POS_W-1:0] position_o,
  output logic                      move_done_o,
  output logic                      rejected_o
);

  logic [stpg_pkg::DUTY_W-1:0]     duty_q;
  logic [stpg_pkg::TICK_W-1:0]     tick_hz_q;
  logic [stpg_pkg::MINP_W-1:0]     minp_q;

  logic [stpg_pkg::POS_W-1:0]      pos_q, target_q;
  logic [stpg_pkg::STEPS_W-1:0]    steps_q, steps_dec;
  logic [stpg_pkg::PERIOD_W-1:0]   period_q, high_q, phase_q;
  logic                            dir_q, active_q;
  logic [stpg_pkg::PROD_W-1:0]     prod_q;
  logic [stpg_pkg::HQ_W-1:0]       hquo_q;
  logic                            level_q, done_q, rej_q;

  logic [stpg_pkg::TICK_W-1:0]     div_dividend, quotient;
  logic [stpg_pkg::RATE_W-1:0]     div_divisor;
  logic                            div_done;
  logic [stpg_pkg::SCALED_W-1:0]   scaled;
  logic [stpg_pkg::PERIOD_W-1:0]   period_d, high_d;
  logic [stpg_pkg::HQ_W-1:0]       high_min;
  logic [stpg_pkg::PERIOD_W:0]     phase_inc;
  logic                            wrap, last, is_move;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = 1'b0 | cmd_i.accept;
  assign is_move     = req_i.command == stpg_pkg::CMD_MOVE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q    <= stpg_pkg::DUTY_RESET;
      tick_hz_q <= stpg_pkg::TICK_HZ_RESET;
      minp_q    <= stpg_pkg::MINP_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        stpg_pkg::CFG_DUTY:      duty_q    <= cfg_i.data[stpg_pkg::DUTY_W-1:0];
        stpg_pkg::CFG_TICK_HZ:   tick_hz_q <= cfg_i.data[stpg_pkg::TICK_W-1:0];
        stpg_pkg::CFG_MIN_PULSE: minp_q    <= cfg_i.data[stpg_pkg::MINP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    div_dividend = tick_hz_q;
    div_divisor  = (req_i.step_rate_hz == '0) ? stpg_pkg::RATE_W'(1) : req_i.step_rate_hz;
  end

  stpg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign scaled = stpg_pkg::SCALED_W'(prod_q) * stpg_pkg::SCALED_W'(stpg_pkg::RECIP_100);

  always_comb begin
    if (quotient < stpg_pkg::TICK_W'(stpg_pkg::PERIOD_MIN)) begin
      period_d = stpg_pkg::PERIOD_MIN;
    end else if (quotient > stpg_pkg::TICK_W'(stpg_pkg::PERIOD_MAX)) begin
      period_d = stpg_pkg::PERIOD_MAX;
    end else begin
      period_d = quotient[stpg_pkg::PERIOD_W-1:0];
    end
    high_min = (hquo_q < stpg_pkg::HQ_W'(minp_q)) ? stpg_pkg::HQ_W'(minp_q) : hquo_q;
    if (high_min >= stpg_pkg::HQ_W'(period_q)) begin
      high_d = period_q - 1'b1;
    end else begin
      high_d = high_min[stpg_pkg::PERIOD_W-1:0];
    end
  end

  always_comb begin
    phase_inc = {1'b0, phase_q} + 1'b1;
    wrap      = phase_inc >= {1'b0, period_q};
    steps_dec = (steps_q != '0) ? steps_q - 1'b1 : steps_q;
    last      = wrap && (steps_dec == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      target_q <= '0;
      steps_q  <= '0;
      period_q <= stpg_pkg::PERIOD_MIN;
      high_q   <= stpg_pkg::HIGH_RESET;
      phase_q  <= '0;
      dir_q    <= 1'b1;
      active_q <= 1'b0;
      level_q  <= 1'b0;
      done_q   <= 1'b0;
      rej_q    <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        level_q <= 1'b0;
        done_q  <= 1'b0;
        rej_q   <= 1'b0;
        if (is_move) begin
          if (active_q) begin
            rej_q <= 1'b1;
          end else begin
            target_q <= req_i.target_position;
            if (req_i.target_position >= pos_q) begin
              dir_q   <= 1'b1;
              steps_q <= stpg_pkg::STEPS_W'(req_i.target_position - pos_q);
            end else begin
              dir_q   <= 1'b0;
              steps_q <= stpg_pkg::STEPS_W'(pos_q - req_i.target_position);
            end
          end
        end else if (active_q) begin
          level_q <= phase_q < high_q;
          if (wrap) begin
            phase_q <= '0;
            steps_q <= steps_dec;
            if (last) begin
              active_q <= 1'b0;
              pos_q    <= target_q;
              done_q   <= 1'b1;
            end
          end else begin
            phase_q <= phase_inc[stpg_pkg::PERIOD_W-1:0];
          end
        end
      end
      if (cmd_i.period_load) begin
        period_q <= period_d;
      end
      if (cmd_i.high_load) begin
        high_q <= high_d;
      end
      if (cmd_i.move_finish) begin
        phase_q <= '0;
        level_q <= 1'b0;
        rej_q   <= 1'b0;
        if (steps_q == '0) begin
          done_q <= 1'b1;
          pos_q  <= target_q;
        end else begin
          done_q   <= 1'b0;
          active_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_load) begin
      prod_q <= stpg_pkg::PROD_W'(period_q) * stpg_pkg::PROD_W'(duty_q);
    end
    if (cmd_i.scale_load) begin
      hquo_q <= scaled[stpg_pkg::SCALED_W-1:stpg_pkg::RECIP_SHIFT];
    end
  end

  assign stat_o.active   = active_q;
  assign stat_o.div_done = div_done;
  assign stat_o.move_req = is_move;

  assign step_level_o = level_q;
  assign direction_o  = dir_q;
  assign active_o     = active_q;
  assign position_o   = pos_q;
  assign move_done_o  = done_q;
  assign rejected_o   = rej_q;

endmodule

`default_nettype wire

// ===== hdl/stpg_ctrl.sv =====
// Controller: accepts requests, sequences the period and high time
// calculations, and owns the result valid flag. Depends on stpg_pkg.
`default_nettype none

module stpg_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 req_valid_i,
  input  wire logic                 rsp_ready_i,
  input  stpg_pkg::ctrl_stat_t      stat_i,
  output stpg_pkg::ctrl_cmd_t       cmd_o,
  output logic                      rsp_valid_o
);

  stpg_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stpg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_free    = !out_valid_q || rsp_ready_i;
    state_d     = state_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      stpg_pkg::ST_IDLE: begin
        if (req_valid_i && out_free) begin
          cmd_o.accept = 1'b1;
          if (stat_i.move_req && !stat_i.active) begin
            cmd_o.div_start = 1'b1;
            state_d         = stpg_pkg::ST_DIV_PERIOD;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      stpg_pkg::ST_DIV_PERIOD: begin
        if (stat_i.div_done) begin
          cmd_o.period_load = 1'b1;
          state_d           = stpg_pkg::ST_MUL;
        end
      end
      stpg_pkg::ST_MUL: begin
        cmd_o.prod_load = 1'b1;
        state_d         = stpg_pkg::ST_SCALE;
      end
      stpg_pkg::ST_SCALE: begin
        cmd_o.scale_load = 1'b1;
        state_d          = stpg_pkg::ST_HIGH;
      end
      stpg_pkg::ST_HIGH: begin
        cmd_o.high_load = 1'b1;
        state_d         = stpg_pkg::ST_FINISH;
      end
      stpg_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd_o.move_finish = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = stpg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stpg_pkg::ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/stepper_step_dir_pulse_generator_unit.sv =====
// Tick and rejected move requests: result registered in the cycle after the request is
// accepted, one request per cycle while results are taken. An accepted move first runs
// the period divider; the controller then loads the period, multiplies, scales, clamps
// and finishes in ST_DIV_PERIOD, ST_MUL, ST_SCALE, ST_HIGH and ST_FINISH.
// Reset restores register defaults (duty 50, tick rate 1000000, minimum pulse 3),
// position 0, direction forward, no move running and no result pending.
`default_nettype none

module stepper_step_dir_pulse_generator_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stpg_req_if.sink   req_i,
  stpg_rsp_if.source rsp_o,
  stpg_cfg_if.sink   cfg_i
);

  stpg_pkg::ctrl_cmd_t  cmd;
  stpg_pkg::ctrl_stat_t stat;
  logic                 active;

  stpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .rsp_valid_o (rsp_o.valid)
  );

  stpg_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_i        (req_i),
    .cfg_i        (cfg_i),
    .step_level_o (rsp_o.step_level),
    .direction_o  (rsp_o.direction),
    .active_o     (active),
    .position_o   (rsp_o.position),
    .move_done_o  (rsp_o.move_done),
    .rejected_o   (rsp_o.rejected)
  );

  assign rsp_o.enable   = active;
  assign rsp_o.busy_res = active;

endmodule

`default_nettype wire

// ===== hdl/stpg_checker.sv =====
// Port-level checks for the pulse generator and the bind that attaches them.
// Depends on the top level's ports only.
`default_nettype none

module stpg_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic step_level,
  input wire logic enable,
  input wire logic busy_res,
  input wire logic move_done,
  input wire logic rejected
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rejected |-> busy_res && enable)
    else $error("move rejected while no move was running");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && move_done |-> !enable && !rejected)
    else $error("move reported done while still enabled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && step_level |-> enable && !move_done)
    else $error("step pulse outside a running move");

endmodule

bind stepper_step_dir_pulse_generator_unit stpg_checker u_stpg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rsp_valid  (rsp_o.valid),
  .rsp_ready  (rsp_o.ready),
  .step_level (rsp_o.step_level),
  .enable     (rsp_o.enable),
  .busy_res   (rsp_o.busy_res),
  .move_done  (rsp_o.move_done),
  .rejected   (rsp_o.rejected)
);

`default_nettype wire

// ===== test/stepper_step_dir_pulse_generator_unit_test.sv =====
// Self-checking testbench for stepper_step_dir_pulse_generator_unit: a scoreboard class
// predicts every result from the accepted requests and register writes under random stalls.
// Depends on stpg_pkg, the stpg interfaces and the unit itself.
`timescale 1ns / 100ps

typedef struct packed {
  logic                       step_level;
  logic                       direction;
  logic                       enable;
  logic                       busy_res;
  logic [stpg_pkg::POS_W-1:0] position;
  logic                       move_done;
  logic                       rejected;
} pulse_result_t;

class pulse_scoreboard;
  logic [stpg_pkg::DUTY_W-1:0]   duty;
  logic [stpg_pkg::TICK_W-1:0]   tick_hz;
  logic [stpg_pkg::MINP_W-1:0]   min_pulse;
  logic [stpg_pkg::POS_W-1:0]    position;
  logic [stpg_pkg::POS_W-1:0]    target;
  logic [stpg_pkg::STEPS_W-1:0]  steps_left;
  logic [stpg_pkg::PERIOD_W-1:0] period;
  logic [stpg_pkg::PERIOD_W-1:0] high_time;
  logic [stpg_pkg::PERIOD_W-1:0] phase;
  logic                          dir;
  logic                          running;
  pulse_result_t                 due_results[$];
  int                            errors;
  int                            seen;

  function new();
    duty       = stpg_pkg::DUTY_RESET;
    tick_hz    = stpg_pkg::TICK_HZ_RESET;
    min_pulse  = stpg_pkg::MINP_RESET;
    position   = '0;
    target     = '0;
    steps_left = '0;
    period     = stpg_pkg::PERIOD_MIN;
    high_time  = stpg_pkg::HIGH_RESET;
    phase      = '0;
    dir        = 1'b1;
    running    = 1'b0;
    errors     = 0;
    seen       = 0;
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function int pending();
    return due_results.size();
  endfunction

  function void write_reg(logic [stpg_pkg::CFG_IDX_W-1:0] idx,
                          logic [stpg_pkg::CFG_DATA_W-1:0] data);
    case (stpg_pkg::cfg_idx_e'(idx))
      stpg_pkg::CFG_DUTY:      duty = data[stpg_pkg::DUTY_W-1:0];
      stpg_pkg::CFG_TICK_HZ:   tick_hz = data[stpg_pkg::TICK_W-1:0];
      stpg_pkg::CFG_MIN_PULSE: min_pulse = data[stpg_pkg::MINP_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [stpg_pkg::PERIOD_W-1:0] period_for(logic [stpg_pkg::RATE_W-1:0] rate);
    longint unsigned q;
    longint unsigned r;
    r = (rate == 0) ? 1 : rate;
    q = tick_hz / r;
    if (q < 2) q = 2;
    if (q > 65535) q = 65535;
    return q[stpg_pkg::PERIOD_W-1:0];
  endfunction

  function logic [stpg_pkg::PERIOD_W-1:0] high_for(logic [stpg_pkg::PERIOD_W-1:0] p);
    longint unsigned h;
    h = (longint'(p) * duty) / 100;
    if (h < min_pulse) h = min_pulse;
    if (h >= p) h = p - 1;
    return h[stpg_pkg::PERIOD_W-1:0];
  endfunction

  function void apply_request(stpg_pkg::cmd_e cmd, logic [stpg_pkg::POS_W-1:0] tgt,
                              logic [stpg_pkg::RATE_W-1:0] rate);
    pulse_result_t r;
    logic [stpg_pkg::STEPS_W-1:0] span;
    r = '0;
    if (cmd == stpg_pkg::CMD_MOVE) begin
      if (running) begin
        r.rejected = 1'b1;
      end else begin
        if (tgt >= position) begin
          dir  = 1'b1;
          span = stpg_pkg::STEPS_W'(tgt - position);
        end else begin
          dir  = 1'b0;
          span = stpg_pkg::STEPS_W'(position - tgt);
        end
        period     = period_for(rate);
        high_time  = high_for(period);
        phase      = '0;
        target     = tgt;
        steps_left = span;
        if (span == 0) begin
          r.move_done = 1'b1;
          position    = tgt;
        end else begin
          running = 1'b1;
        end
      end
    end else if (running) begin
      r.step_level = (phase < high_time);
      phase = phase + 1'b1;
      if (phase >= period) begin
        phase = '0;
        if (steps_left > 0) steps_left = steps_left - 1'b1;
        if (steps_left == 0) begin
          running     = 1'b0;
          position    = target;
          r.move_done = 1'b1;
        end
      end
    end
    r.direction = dir;
    r.enable    = running;
    r.busy_res  = running;
    r.position  = position;
    due_results.push_back(r);
  endfunction

  task cmp_field(string name, logic [stpg_pkg::POS_W-1:0] got,
                 logic [stpg_pkg::POS_W-1:0] want);
    if (got !== want)
      report($sformatf("result %0d field %s: got %0h, expected %0h", seen, name, got, want));
  endtask

  task check_result(pulse_result_t got);
    pulse_result_t want;
    if (due_results.size() == 0) begin
      report("result arrived with no request outstanding");
      return;
    end
    want = due_results.pop_front();
    cmp_field("step_level", got.step_level, want.step_level);
    cmp_field("direction", got.direction, want.direction);
    cmp_field("enable", got.enable, want.enable);
    cmp_field("busy_res", got.busy_res, want.busy_res);
    cmp_field("position", got.position, want.position);
    cmp_field("move_done", got.move_done, want.move_done);
    cmp_field("rejected", got.rejected, want.rejected);
    seen++;
  endtask
endclass

module stepper_step_dir_pulse_generator_unit_test;

  localparam int unsigned                          LIMIT     = 1000000;
  localparam logic [stpg_pkg::CFG_IDX_W-1:0]       CFG_SPARE = 2'd3;
  localparam logic [stpg_pkg::RATE_W-1:0]          RATE_TOP  = {stpg_pkg::RATE_W{1'b1}};

  logic            clk_i;
  logic            rst_ni;
  logic            calm;
  int unsigned     cycles = 0;
  pulse_scoreboard sb;

  stpg_req_if req ();
  stpg_rsp_if rsp ();
  stpg_cfg_if cfg ();

  stepper_step_dir_pulse_generator_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("** stepper_step_dir_pulse_generator_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready)
      sb.check_result({rsp.step_level, rsp.direction, rsp.enable, rsp.busy_res,
                       rsp.position, rsp.move_done, rsp.rejected});
  end

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp.ready <= rst_ni && (calm || ($urandom_range(99) >= 9));
    end
  end

  task automatic send_request(stpg_pkg::cmd_e cmd, logic [stpg_pkg::POS_W-1:0] tgt,
                              logic [stpg_pkg::RATE_W-1:0] rate);
    while (!calm && $urandom_range(99) < 9) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid           <= 1'b1;
    req.command         <= cmd;
    req.target_position <= tgt;
    req.step_rate_hz    <= rate;
    do @(posedge clk_i); while (!req.ready);
    sb.apply_request(cmd, tgt, rate);
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_request(stpg_pkg::CMD_TICK, stpg_pkg::POS_W'($urandom),
                 stpg_pkg::RATE_W'($urandom));
  endtask

  task automatic finish_move();
    while (sb.running) send_tick();
  endtask

  task automatic hold_until_drained();
    req.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [stpg_pkg::CFG_IDX_W-1:0] idx,
                           logic [stpg_pkg::CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_regs(int unsigned duty, int unsigned tick_hz, int unsigned min_pulse,
                          bit junk);
    logic [stpg_pkg::CFG_DATA_W-1:0] noise;
    hold_until_drained();
    repeat (4) @(negedge clk_i);
    noise = junk ? $urandom : '0;
    write_reg(stpg_pkg::CFG_DUTY, (noise & ~32'h7F) | duty);
    noise = junk ? $urandom : '0;
    write_reg(stpg_pkg::CFG_TICK_HZ, (noise & ~32'h7FF_FFFF) | tick_hz);
    noise = junk ? $urandom : '0;
    write_reg(stpg_pkg::CFG_MIN_PULSE, (noise & ~32'hFFFF) | min_pulse);
  endtask

  task automatic start_move(int unsigned rate_lo, int unsigned rate_hi, int unsigned dist_max);
    int unsigned                 pick;
    int unsigned                 d;
    int                          cur;
    logic [stpg_pkg::POS_W-1:0]  tgt;
    logic [stpg_pkg::RATE_W-1:0] rate;
    pick = $urandom_range(99);
    cur  = int'(sb.position);
    if (dist_max > 1 && pick < 4) begin
      tgt = (pick < 2) ? '0 : '1;
    end else if (dist_max > 1 && pick < 12) begin
      tgt = stpg_pkg::POS_W'($urandom);
    end else if (pick < 18) begin
      tgt = stpg_pkg::POS_W'(cur);
    end else begin
      d = $urandom_range(dist_max, 1);
      if ((($urandom & 1) == 1 && cur >= d) || cur + d > 255)
        tgt = stpg_pkg::POS_W'(cur - d);
      else
        tgt = stpg_pkg::POS_W'(cur + d);
    end
    if (rate_lo == 0 && $urandom_range(99) < 3)
      rate = '0;
    else
      rate = stpg_pkg::RATE_W'($urandom_range(rate_hi, rate_lo));
    send_request(stpg_pkg::CMD_MOVE, tgt, rate);
  endtask

  task automatic run_phase(int unsigned count, int unsigned rate_lo, int unsigned rate_hi,
                           int unsigned dist_max);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      if (sent == count / 2)
        hold_until_drained();
      if (sb.running) begin
        if ($urandom_range(99) < 6)
          send_request(stpg_pkg::CMD_MOVE, stpg_pkg::POS_W'($urandom),
                       stpg_pkg::RATE_W'($urandom));
        else
          send_tick();
        sent++;
      end else if ($urandom_range(99) < 8) begin
        send_tick();
      end else begin
        start_move(rate_lo, rate_hi, dist_max);
        sent++;
      end
    end
    finish_move();
  endtask

  initial begin
    sb                  = new();
    calm                = 1'b0;
    rst_ni              = 1'b0;
    req.valid           = 1'b0;
    req.command         = stpg_pkg::CMD_TICK;
    req.target_position = '0;
    req.step_rate_hz    = '0;
    cfg.valid           = 1'b0;
    cfg.index           = stpg_pkg::CFG_DUTY;
    cfg.data            = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(stpg_pkg::CMD_TICK, '1, RATE_TOP);
    send_request(stpg_pkg::CMD_MOVE, '0, '0);
    send_request(stpg_pkg::CMD_MOVE, stpg_pkg::POS_W'(2), stpg_pkg::RATE_W'(1000000));
    send_request(stpg_pkg::CMD_MOVE, stpg_pkg::POS_W'(200), stpg_pkg::RATE_W'(7));
    finish_move();
    send_request(stpg_pkg::CMD_MOVE, '0, RATE_TOP);
    send_tick();
    send_request(stpg_pkg::CMD_MOVE, '1, '0);
    finish_move();
    send_request(stpg_pkg::CMD_MOVE, stpg_pkg::POS_W'(1), stpg_pkg::RATE_W'(250000));
    finish_move();

    run_phase(300, 200000, RATE_TOP, 8);
    set_regs(100, 40, 0, 1'b0);
    run_phase(250, 0, RATE_TOP, 12);
    calm = 1'b1;
    set_regs(1, 300, 0, 1'b0);
    run_phase(200, 10, 300, 8);
    calm = 1'b0;
    set_regs(127, 27'h7FF_FFFF, 16'hFFFF, 1'b0);
    write_reg(CFG_SPARE, $urandom);
    run_phase(300, 600000, RATE_TOP, 1);
    set_regs(0, 1, 5, 1'b0);
    run_phase(200, 0, RATE_TOP, 12);
    set_regs(37, 1000, 2, 1'b1);
    run_phase(250, 100, 1000, 10);
    set_regs(100, 0, 16'hFFFF, 1'b0);
    run_phase(100, 0, RATE_TOP, 8);

    hold_until_drained();
    repeat (20) @(negedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("** stepper_step_dir_pulse_generator_unit: PASSED **");
    end else begin
      $display("** stepper_step_dir_pulse_generator_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== stepper_step_dir_pulse_generator_unit.f =====
hdl/stpg_pkg.sv
hdl/stpg_if.sv
hdl/stpg_div.sv
hdl/stpg_datapath.sv
hdl/stpg_ctrl.sv
hdl/stepper_step_dir_pulse_generator_unit.sv
hdl/stpg_checker.sv
test/stepper_step_dir_pulse_generator_unit_test.sv
